// ===== hw/rtl/acm_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the crossfade contour mixer.
// No dependencies; every other file in hw/rtl except acm_if uses it.
package acm_pkg;

	localparam int SAMPLE_BITS_DEF       = 24;
	localparam int FRAME_BITS_DEF        = 24;
	localparam int COSINE_TABLE_SIZE_DEF = 512;

	// Configuration port geometry
	localparam int CFG_BITS     = 24;
	localparam int CFG_IDX_BITS = 2;

	// Fade position, weight and skew widths
	localparam int POS_BITS    = 24;
	localparam int WEIGHT_BITS = 25;
	localparam int SKEW_BITS   = 16;

	localparam logic [WEIGHT_BITS-1:0] ONE_Q24  = 25'h100_0000;
	localparam logic [SKEW_BITS-1:0]   SKEW_MIN = 16'd512;
	localparam logic [SKEW_BITS-1:0]   SKEW_MAX = 16'd32768;
	localparam logic [SKEW_BITS-1:0]   SKEW_RST = 16'd4096;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_FADE_START = 2'd0,
		REG_FADE_END   = 2'd1,
		REG_COSINE     = 2'd2,
		REG_SKEW       = 2'd3
	} cfg_reg_t;

	// Where a frame sits relative to the fade
	typedef enum logic [1:0] {
		SPAN_BEFORE = 2'd0,
		SPAN_AFTER  = 2'd1,
		SPAN_RAMP   = 2'd2
	} span_t;

	// Classified job handed from the front to the back
	typedef struct packed {
		span_t                  span;
		logic                   last;
		logic                   cosine;
		logic [SKEW_BITS-1:0]   skew;
		logic [POS_BITS-1:0]    num;
		logic [WEIGHT_BITS-1:0] den;
	} job_t;

endpackage

// ===== hw/rtl/acm_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the sample input and blended output.
// Depends on nothing; sized by SAMPLE_BITS.
interface acm_in_if #(
	parameter int SAMPLE_BITS = 24
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] outgoing_sample;
	logic signed [SAMPLE_BITS-1:0] incoming_sample;
	logic                          end_of_channel;

	modport source (output valid, outgoing_sample, incoming_sample, end_of_channel,
		input ready);
	modport sink (input valid, outgoing_sample, incoming_sample, end_of_channel,
		output ready);
endinterface

interface acm_out_if #(
	parameter int SAMPLE_BITS = 24
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] blended_sample;
	logic                          blend_last;

	modport source (output valid, blended_sample, blend_last, input ready);
	modport sink (input valid, blended_sample, blend_last, output ready);
endinterface

// ===== hw/rtl/audio_crossfade_contour_mixer_core.sv =====
`timescale 1ns / 1ps
// Top level of the crossfade contour mixer: front end, job queue, back end.
// Depends on acm_pkg, acm_if, acm_front, acm_queue and acm_back.
//
//  channel  dir  handshake     word
//  in_ch    in   valid/ready   outgoing_sample, incoming_sample, end_of_channel
//  out_ch   out  valid/ready   blended_sample, blend_last
//  cfg      in   cfg_we        cfg_index selects register, cfg_data value
//
// A frame outside the fade is picked up and blended in the back end;
// a linear ramp frame first passes the one-bit-per-cycle divider.
// A raised-cosine frame adds squaring, a serial square root plus a multiply
// (one root per skew bit from bit 11 down to the lowest set bit, a multiply
// for each set bit among them), then the table lookup and interpolation.
// The front end takes a word every cycle while the two-entry queue has room;
// a stalled output register holds the back end, which then fills the queue.
// Reset clears the registers to their defaults and the frame counter to zero.
module audio_crossfade_contour_mixer_core #(
	parameter int SAMPLE_BITS       = acm_pkg::SAMPLE_BITS_DEF,
	parameter int FRAME_BITS        = acm_pkg::FRAME_BITS_DEF,
	parameter int COSINE_TABLE_SIZE = acm_pkg::COSINE_TABLE_SIZE_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [acm_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [acm_pkg::CFG_BITS-1:0]     cfg_data,
	acm_in_if.sink                           in_ch,
	acm_out_if.source                        out_ch
);

	logic                          q_full;
	logic                          q_push;
	logic                          q_empty;
	logic                          q_pop;
	acm_pkg::job_t                 push_job;
	acm_pkg::job_t                 head_job;
	logic signed [SAMPLE_BITS-1:0] push_a;
	logic signed [SAMPLE_BITS-1:0] push_b;
	logic signed [SAMPLE_BITS-1:0] head_a;
	logic signed [SAMPLE_BITS-1:0] head_b;

	acm_front #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.FRAME_BITS (FRAME_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_ch    (in_ch),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_job    (push_job),
		.q_a      (push_a),
		.q_b      (push_b)
	);

	acm_queue #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.push_job(push_job),
		.push_a  (push_a),
		.push_b  (push_b),
		.full    (q_full),
		.pop     (q_pop),
		.empty   (q_empty),
		.head_job(head_job),
		.head_a  (head_a),
		.head_b  (head_b)
	);

	acm_back #(
		.SAMPLE_BITS      (SAMPLE_BITS),
		.COSINE_TABLE_SIZE(COSINE_TABLE_SIZE)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.empty   (q_empty),
		.head_job(head_job),
		.head_a  (head_a),
		.head_b  (head_b),
		.pop     (q_pop),
		.out_ch  (out_ch)
	);

endmodule

// ===== hw/rtl/acm_front.sv =====
`timescale 1ns / 1ps
// Front end: configuration registers, frame counter and frame classification.
// Depends on acm_pkg and acm_in_if; feeds acm_queue.
module acm_front #(
	parameter int SAMPLE_BITS = acm_pkg::SAMPLE_BITS_DEF,
	parameter int FRAME_BITS  = acm_pkg::FRAME_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [acm_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  logic [acm_pkg::CFG_BITS-1:0]        cfg_data,
	acm_in_if.sink                              in_ch,
	input  logic                                q_full,
	output logic                                q_push,
	output acm_pkg::job_t                       q_job,
	output logic signed [SAMPLE_BITS-1:0]       q_a,
	output logic signed [SAMPLE_BITS-1:0]       q_b
);

	localparam int CMP_BITS = (FRAME_BITS > acm_pkg::WEIGHT_BITS) ? FRAME_BITS
		: acm_pkg::WEIGHT_BITS;

	logic [acm_pkg::POS_BITS-1:0]    fade_start_q;
	logic [acm_pkg::POS_BITS-1:0]    fade_end_q;
	logic                            cosine_q;
	logic [acm_pkg::SKEW_BITS-1:0]   skew_q;
	logic [FRAME_BITS-1:0]           frame_q;

	logic [acm_pkg::WEIGHT_BITS-1:0] end_eff;
	logic [CMP_BITS-1:0]             i_w;
	logic [CMP_BITS-1:0]             s_w;
	logic [CMP_BITS-1:0]             e_w;
	logic [CMP_BITS-1:0]             diff;
	logic [acm_pkg::SKEW_BITS-1:0]   skew_clamped;
	logic                            accept;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fade_start_q <= '0;
			fade_end_q   <= acm_pkg::POS_BITS'(1);
			cosine_q     <= 1'b1;
			skew_q       <= acm_pkg::SKEW_RST;
		end else if (cfg_we) begin
			case (acm_pkg::cfg_reg_t'(cfg_index))
				acm_pkg::REG_FADE_START: fade_start_q <= cfg_data;
				acm_pkg::REG_FADE_END:   fade_end_q   <= cfg_data;
				acm_pkg::REG_COSINE:     cosine_q     <= cfg_data[0];
				acm_pkg::REG_SKEW:       skew_q       <= cfg_data[acm_pkg::SKEW_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Force the end above the start, then classify the current frame
	always_comb begin
		if (fade_end_q <= fade_start_q) begin
			end_eff = {1'b0, fade_start_q} + acm_pkg::WEIGHT_BITS'(1);
		end else begin
			end_eff = {1'b0, fade_end_q};
		end
		i_w  = CMP_BITS'(frame_q);
		s_w  = CMP_BITS'(fade_start_q);
		e_w  = CMP_BITS'(end_eff);
		diff = i_w - s_w;
		if (skew_q < acm_pkg::SKEW_MIN) begin
			skew_clamped = acm_pkg::SKEW_MIN;
		end else if (skew_q > acm_pkg::SKEW_MAX) begin
			skew_clamped = acm_pkg::SKEW_MAX;
		end else begin
			skew_clamped = skew_q;
		end
		if (i_w <= s_w) begin
			q_job.span = acm_pkg::SPAN_BEFORE;
		end else if (i_w >= e_w) begin
			q_job.span = acm_pkg::SPAN_AFTER;
		end else begin
			q_job.span = acm_pkg::SPAN_RAMP;
		end
		q_job.last   = in_ch.end_of_channel;
		q_job.cosine = cosine_q;
		q_job.skew   = skew_clamped;
		q_job.num    = diff[acm_pkg::POS_BITS-1:0];
		q_job.den    = end_eff - {1'b0, fade_start_q};
	end

	assign accept      = in_ch.valid && !q_full;
	assign in_ch.ready = !q_full;
	assign q_push      = accept;
	assign q_a         = in_ch.outgoing_sample;
	assign q_b         = in_ch.incoming_sample;

	// Advance the frame counter, restart after the last frame of a channel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_q <= '0;
		end else if (accept) begin
			if (in_ch.end_of_channel) begin
				frame_q <= '0;
			end else begin
				frame_q <= frame_q + FRAME_BITS'(1);
			end
		end
	end

endmodule

// ===== hw/rtl/acm_queue.sv =====
`timescale 1ns / 1ps
// Two-entry job queue between the front end and the back end.
// Depends on acm_pkg.
module acm_queue #(
	parameter int SAMPLE_BITS = acm_pkg::SAMPLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	input  acm_pkg::job_t                 push_job,
	input  logic signed [SAMPLE_BITS-1:0] push_a,
	input  logic signed [SAMPLE_BITS-1:0] push_b,
	output logic                          full,
	input  logic                          pop,
	output logic                          empty,
	output acm_pkg::job_t                 head_job,
	output logic signed [SAMPLE_BITS-1:0] head_a,
	output logic signed [SAMPLE_BITS-1:0] head_b
);

	acm_pkg::job_t                 job_q [2];
	logic signed [SAMPLE_BITS-1:0] a_q [2];
	logic signed [SAMPLE_BITS-1:0] b_q [2];
	logic                          wr_ptr_q;
	logic                          rd_ptr_q;
	logic [1:0]                    count_q;

	assign full     = (count_q == 2'd2);
	assign empty    = (count_q == 2'd0);
	assign head_job = job_q[rd_ptr_q];
	assign head_a   = a_q[rd_ptr_q];
	assign head_b   = b_q[rd_ptr_q];

	// Store words
	always_ff @(posedge clk) begin
		if (push) begin
			job_q[wr_ptr_q] <= push_job;
			a_q[wr_ptr_q]   <= push_a;
			b_q[wr_ptr_q]   <= push_b;
		end
	end

	// Track pointers and fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

// ===== hw/rtl/acm_back.sv =====
`timescale 1ns / 1ps
// Back end: serial divider, skew power by squaring and serial square root,
// contour ROM interpolation, blend and output register. Depends on acm_pkg.
module acm_back #(
	parameter int SAMPLE_BITS       = acm_pkg::SAMPLE_BITS_DEF,
	parameter int COSINE_TABLE_SIZE = acm_pkg::COSINE_TABLE_SIZE_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          empty,
	input  acm_pkg::job_t                 head_job,
	input  logic signed [SAMPLE_BITS-1:0] head_a,
	input  logic signed [SAMPLE_BITS-1:0] head_b,
	output logic                          pop,
	acm_out_if.source                     out_ch
);

	localparam int WB = acm_pkg::WEIGHT_BITS;
	localparam int PB = acm_pkg::POS_BITS;
	localparam int JW = $clog2(COSINE_TABLE_SIZE + 1);
	localparam logic [JW-1:0] TOP_IDX = JW'(COSINE_TABLE_SIZE);
	localparam longint unsigned PI_Q30 = 64'd3373259426;

	// Quarter-turn angle step and Taylor series divisors
	localparam longint unsigned ANGLE_DEN  = 64'(2 * COSINE_TABLE_SIZE);
	localparam longint unsigned TAYLOR_D3  = 64'd6;
	localparam longint unsigned TAYLOR_D5  = 64'd20;
	localparam longint unsigned TAYLOR_D7  = 64'd42;
	localparam longint unsigned TAYLOR_D9  = 64'd72;
	localparam longint unsigned TAYLOR_D11 = 64'd110;

	typedef logic [WB-1:0] rom_t [COSINE_TABLE_SIZE+1];

	// sin^2 table over a quarter turn, Q0.24
	function automatic rom_t rom_init();
		rom_t            tab;
		longint unsigned u;
		longint unsigned u2;
		longint unsigned term;
		longint unsigned prod;
		longint unsigned sum;
		longint unsigned sq;
		int              n;
		for (int k = 0; k <= COSINE_TABLE_SIZE; k++) begin
			u    = (PI_Q30 * 64'(k)) / ANGLE_DEN;
			u2   = (u * u) >> 30;
			term = u;
			sum  = u;
			for (n = 1; n <= 9; n += 2) begin
				prod = (term * u2) >> 30;
				case (n)
					1: begin
						term = prod / TAYLOR_D3;
						sum  = sum - term;
					end
					3: begin
						term = prod / TAYLOR_D5;
						sum  = sum + term;
					end
					5: begin
						term = prod / TAYLOR_D7;
						sum  = sum - term;
					end
					7: begin
						term = prod / TAYLOR_D9;
						sum  = sum + term;
					end
					default: begin
						term = prod / TAYLOR_D11;
						sum  = sum - term;
					end
				endcase
			end
			if (sum > (64'd1 << 30)) begin
				sum = 64'd1 << 30;
			end
			sq = (sum * sum) >> 36;
			if (sq > (64'd1 << 24)) begin
				sq = 64'd1 << 24;
			end
			tab[k] = sq[WB-1:0];
		end
		return tab;
	endfunction

	localparam rom_t CONTOUR_ROM = rom_init();

	typedef enum logic [3:0] {
		B_IDLE, B_DIV, B_UP_MUL, B_UP_SQ, B_SQRT, B_DN_MUL,
		B_POS, B_ROM, B_INTERP, B_BLEND
	} bstate_t;

	bstate_t                       state_q;
	logic signed [SAMPLE_BITS-1:0] a_q;
	logic signed [SAMPLE_BITS-1:0] b_q;
	logic                          last_q;
	logic                          cosine_q;
	logic [acm_pkg::SKEW_BITS-1:0] skew_q;
	logic [PB-1:0]                 rem_q;
	logic [WB-1:0]                 den_q;
	logic [PB-1:0]                 quo_q;
	logic [4:0]                    cnt_q;
	logic [3:0]                    k_q;
	logic [WB-1:0]                 acc_q;
	logic [WB-1:0]                 up_q;
	logic [PB-1:0]                 dn_q;
	logic [PB-1:0]                 sq_src_q;
	logic [PB+1:0]                 sq_rem_q;
	logic [PB-1:0]                 sq_root_q;
	logic [WB-1:0]                 w_q;
	logic [JW-1:0]                 idx0_q;
	logic [JW-1:0]                 idx1_q;
	logic [PB-1:0]                 f_q;
	logic [WB-1:0]                 t0_q;
	logic [WB-1:0]                 t1_q;
	logic                          out_valid_q;
	logic signed [SAMPLE_BITS-1:0] out_sample_q;
	logic                          out_last_q;

	logic [PB+1:0]                 div_shift;
	logic                          div_bit;
	logic [PB-1:0]                 div_rem;
	logic [PB-1:0]                 ratio;
	logic [2*WB-1:0]               mul_prod;
	logic [WB-1:0]                 mul_q24;
	logic [PB+3:0]                 sq_shift;
	logic [PB+3:0]                 sq_trial;
	logic                          sq_take;
	logic [PB-1:0]                 sq_root_n;
	logic [acm_pkg::SKEW_BITS-1:0] low_mask;
	logic                          more_down;
	logic [WB+JW-1:0]              pos;
	logic [JW-1:0]                 pos_j;
	logic signed [WB:0]            t_diff;
	logic signed [2*WB+1:0]        interp_sum;
	logic signed [SAMPLE_BITS:0]   bl_diff;
	logic signed [SAMPLE_BITS+WB+2:0] bl_sum;
	logic                          out_free;

	// Divider step: one quotient bit
	always_comb begin
		div_shift = {1'b0, rem_q, 1'b0};
		div_bit   = (div_shift >= (PB+2)'(den_q));
		div_rem   = div_bit ? PB'(div_shift - (PB+2)'(den_q)) : div_shift[PB-1:0];
		ratio     = {quo_q[PB-2:0], div_bit};
	end

	// Shared Q0.24 multiply for the power steps
	always_comb begin
		case (state_q)
			B_UP_MUL: mul_prod = acc_q * up_q;
			B_UP_SQ:  mul_prod = up_q * up_q;
			B_DN_MUL: mul_prod = acc_q * WB'(dn_q);
			default:  mul_prod = '0;
		endcase
		mul_q24 = mul_prod[PB +: WB];
	end

	// Square-root step: one root bit from two radicand bits
	always_comb begin
		sq_shift  = {sq_rem_q, sq_src_q[PB-1 -: 2]};
		sq_trial  = (PB+4)'({sq_root_q, 2'b01});
		sq_take   = (sq_shift >= sq_trial);
		sq_root_n = {sq_root_q[PB-2:0], sq_take};
		low_mask  = (acm_pkg::SKEW_BITS'(1) << k_q) - acm_pkg::SKEW_BITS'(1);
		more_down = (k_q != 4'd0) && ((skew_q & low_mask) != '0);
	end

	// Table position, interpolation and blend
	always_comb begin
		pos        = acc_q * (WB+JW)'(COSINE_TABLE_SIZE);
		pos_j      = pos[PB +: JW];
		t_diff     = $signed({1'b0, t1_q}) - $signed({1'b0, t0_q});
		interp_sum = $signed({1'b0, t0_q, {PB{1'b0}}})
			+ (t_diff * $signed({1'b0, f_q}));
		bl_diff    = $signed({b_q[SAMPLE_BITS-1], b_q})
			- $signed({a_q[SAMPLE_BITS-1], a_q});
		bl_sum     = ((SAMPLE_BITS+WB+3)'(a_q) <<< PB)
			+ (bl_diff * $signed({1'b0, w_q}))
			+ $signed((SAMPLE_BITS+WB+3)'(1) << (PB - 1));
	end

	assign out_free = !out_valid_q || out_ch.ready;
	assign pop      = (state_q == B_IDLE) && !empty;

	assign out_ch.valid          = out_valid_q;
	assign out_ch.blended_sample = out_sample_q;
	assign out_ch.blend_last     = out_last_q;

	// Sequence one job through the back end and hold the output word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= B_IDLE;
			out_valid_q  <= 1'b0;
			out_sample_q <= '0;
			out_last_q   <= 1'b0;
			a_q          <= '0;
			b_q          <= '0;
			last_q       <= 1'b0;
			cosine_q     <= 1'b0;
			skew_q       <= '0;
			rem_q        <= '0;
			den_q        <= '0;
			quo_q        <= '0;
			cnt_q        <= '0;
			k_q          <= '0;
			acc_q        <= '0;
			up_q         <= '0;
			dn_q         <= '0;
			sq_src_q     <= '0;
			sq_rem_q     <= '0;
			sq_root_q    <= '0;
			w_q          <= '0;
			idx0_q       <= '0;
			idx1_q       <= '0;
			f_q          <= '0;
			t0_q         <= '0;
			t1_q         <= '0;
		end else begin
			// Load a new output word or drop the one just taken
			if ((state_q == B_BLEND) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				B_IDLE: begin
					if (!empty) begin
						a_q      <= head_a;
						b_q      <= head_b;
						last_q   <= head_job.last;
						cosine_q <= head_job.cosine;
						skew_q   <= head_job.skew;
						rem_q    <= head_job.num;
						den_q    <= head_job.den;
						quo_q    <= '0;
						cnt_q    <= '0;
						case (head_job.span)
							acm_pkg::SPAN_BEFORE: begin
								w_q     <= '0;
								state_q <= B_BLEND;
							end
							acm_pkg::SPAN_AFTER: begin
								w_q     <= acm_pkg::ONE_Q24;
								state_q <= B_BLEND;
							end
							default: state_q <= B_DIV;
						endcase
					end
				end
				B_DIV: begin
					rem_q <= div_rem;
					quo_q <= ratio;
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'(PB - 1)) begin
						if (cosine_q) begin
							acc_q   <= acm_pkg::ONE_Q24;
							up_q    <= WB'(ratio);
							dn_q    <= ratio;
							k_q     <= 4'd12;
							state_q <= B_UP_MUL;
						end else begin
							w_q     <= WB'(ratio);
							state_q <= B_BLEND;
						end
					end
				end
				B_UP_MUL: begin
					if (skew_q[k_q]) begin
						acc_q <= mul_q24;
					end
					state_q <= B_UP_SQ;
				end
				B_UP_SQ: begin
					up_q <= mul_q24;
					cnt_q <= '0;
					sq_src_q <= dn_q;
					sq_rem_q <= '0;
					sq_root_q <= '0;
					if (k_q == 4'd15) begin
						k_q <= 4'd11;
						state_q <= (skew_q[11:0] != '0) ? B_SQRT : B_POS;
					end else begin
						k_q <= k_q + 4'd1;
						state_q <= B_UP_MUL;
					end
				end
				B_SQRT: begin
					if (cnt_q == 5'(PB - 1)) begin
						// Root done: keep it and restart on it for the next level
						dn_q <= sq_root_n;
						cnt_q <= '0;
						sq_src_q <= sq_root_n;
						sq_rem_q <= '0;
						sq_root_q <= '0;
						if (skew_q[k_q]) begin
							state_q <= B_DN_MUL;
						end else if (more_down) begin
							k_q <= k_q - 4'd1;
						end else begin
							state_q <= B_POS;
						end
					end else begin
						sq_rem_q  <= sq_take ? (PB+2)'(sq_shift - sq_trial)
							: (PB+2)'(sq_shift);
						sq_root_q <= sq_root_n;
						sq_src_q  <= {sq_src_q[PB-3:0], 2'b00};
						cnt_q     <= cnt_q + 5'd1;
					end
				end
				B_DN_MUL: begin
					acc_q <= mul_q24;
					if (more_down) begin
						k_q <= k_q - 4'd1;
						state_q <= B_SQRT;
					end else begin
						state_q <= B_POS;
					end
				end
				B_POS: begin
					if (pos_j >= TOP_IDX) begin
						idx0_q <= TOP_IDX;
						idx1_q <= TOP_IDX;
						f_q    <= '0;
					end else begin
						idx0_q <= pos_j;
						idx1_q <= pos_j + JW'(1);
						f_q    <= pos[PB-1:0];
					end
					state_q <= B_ROM;
				end
				B_ROM: begin
					t0_q    <= CONTOUR_ROM[idx0_q];
					t1_q    <= CONTOUR_ROM[idx1_q];
					state_q <= B_INTERP;
				end
				B_INTERP: begin
					w_q     <= interp_sum[PB +: WB];
					state_q <= B_BLEND;
				end
				B_BLEND: begin
					if (out_free) begin
						out_sample_q <= bl_sum[PB +: SAMPLE_BITS];
						out_last_q   <= last_q;
						state_q      <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

endmodule

// ===== hw/rtl/acm_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the crossfade contour mixer, bound to the top level.
// Depends on acm_pkg and the top level's channel ports.
module acm_checker #(
	parameter int SAMPLE_BITS = acm_pkg::SAMPLE_BITS_DEF
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_valid,
	input logic                   in_ready,
	input logic                   out_valid,
	input logic                   out_ready,
	input logic [SAMPLE_BITS-1:0] out_sample,
	input logic                   out_last
);

	logic [2:0] pending_q;

	// Count words taken in but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			pending_q <= pending_q + 3'(in_valid && in_ready) - 3'(out_valid && out_ready);
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output word dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_sample) && $stable(out_last))
		else $error("output word changed while stalled");

	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pending_q != 3'd0)
		else $error("output word without a pending input word");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q == 3'd4 |-> !in_ready)
		else $error("input taken beyond the block's capacity");

endmodule

bind audio_crossfade_contour_mixer_core acm_checker #(
	.SAMPLE_BITS(SAMPLE_BITS)
) u_acm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_sample(out_ch.blended_sample),
	.out_last  (out_ch.blend_last)
);

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for audio_crossfade_contour_mixer_core: random and directed
// frames through the crossfade, checked word by word against a built-in weight/blend predictor.
// Depends on acm_pkg, acm_if and the mixer core RTL.
module tb_top;

	localparam longint unsigned ONE = 64'd1 << 24;
	localparam int TBL = acm_pkg::COSINE_TABLE_SIZE_DEF;

	typedef struct {
		logic [23:0] a;
		logic [23:0] b;
		logic        eoc;
	} frame_t;

	typedef struct {
		logic [23:0] sample;
		logic        last;
	} blend_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [acm_pkg::CFG_IDX_BITS-1:0] cfg_index = '0;
	logic [acm_pkg::CFG_BITS-1:0] cfg_data = '0;

	acm_in_if #(.SAMPLE_BITS(24)) in_ch ();
	acm_out_if #(.SAMPLE_BITS(24)) out_ch ();

	audio_crossfade_contour_mixer_core u_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_ch(in_ch), .out_ch(out_ch)
	);

	always #10 clk = ~clk;

	frame_t frames_to_send[$];
	blend_t blends_due[$];
	int errors = 0;
	bit quiet = 0;
	int out_hold = 0;
	logic in_fire = 1'b0;

	// Predictor state
	longint unsigned sin2_rom [0:TBL];
	longint unsigned p_start = 0, p_end = 1, p_cos = 1, p_skew = 4096, p_frame = 0;

	function automatic longint unsigned sine_q30(longint unsigned u);
		longint unsigned u2, term, sum, n;
		u2 = (u * u) >> 30;
		term = u;
		sum = u;
		for (n = 1; n <= 9; n += 2) begin
			term = ((term * u2) >> 30) / ((n + 1) * (n + 2));
			if (((n + 1) / 2) % 2 == 1) sum = sum - term;
			else sum = sum + term;
		end
		return sum;
	endfunction

	function automatic longint unsigned floor_sqrt(longint unsigned v);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v = v - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	function automatic longint unsigned bend_ratio(longint unsigned r, longint unsigned p);
		longint unsigned acc, up, dn;
		acc = ONE;
		up = r;
		dn = r;
		for (int k = 12; k <= 15; k++) begin
			if (p[k]) acc = (acc * up) >> 24;
			up = (up * up) >> 24;
		end
		for (int k = 11; k >= 0; k--) begin
			dn = floor_sqrt(dn << 24);
			if (p[k]) acc = (acc * dn) >> 24;
		end
		return acc;
	endfunction

	function automatic longint unsigned cosine_lookup(longint unsigned y);
		longint unsigned pos, j, f;
		pos = y * TBL;
		j = pos >> 24;
		f = pos & (ONE - 1);
		if (j >= TBL) return sin2_rom[TBL];
		return (sin2_rom[j] * (ONE - f) + sin2_rom[j + 1] * f) >> 24;
	endfunction

	// Work out the blend for one frame and advance the frame counter
	function automatic blend_t predict_blend(frame_t fr);
		longint unsigned e, w, r, p;
		longint a, b, v;
		blend_t res;
		e = (p_end <= p_start) ? p_start + 1 : p_end;
		if (p_frame <= p_start) begin
			w = 0;
		end else if (p_frame >= e) begin
			w = ONE;
		end else begin
			r = ((p_frame - p_start) << 24) / (e - p_start);
			if (p_cos != 0) begin
				p = p_skew;
				if (p < 512) p = 512;
				if (p > 32768) p = 32768;
				w = cosine_lookup(bend_ratio(r, p));
			end else begin
				w = r;
			end
		end
		a = longint'($signed(fr.a));
		b = longint'($signed(fr.b));
		v = a * longint'(ONE - w) + b * longint'(w) + (64'sd1 <<< 23);
		v = v >>> 24;
		res.sample = v[23:0];
		res.last = fr.eoc;
		p_frame = fr.eoc ? 0 : ((p_frame + 1) & (ONE - 1));
		return res;
	endfunction

	task automatic report_mismatch(string msg);
		$display("MISMATCH at %0t: %s", $realtime, msg);
		errors++;
	endtask

	// Append one frame to the pending list
	task automatic queue_frame(logic [23:0] a, logic [23:0] b, logic eoc);
		frame_t fr;
		fr.a = a;
		fr.b = b;
		fr.eoc = eoc;
		frames_to_send.insert(frames_to_send.size(), fr);
	endtask

	// Monitor: predict on accepted input words, track register writes, check output words
	always @(posedge clk) begin
		blend_t got, want, due;
		frame_t seen;
		in_fire <= in_ch.valid & in_ch.ready;
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready) begin
				seen.a = in_ch.outgoing_sample;
				seen.b = in_ch.incoming_sample;
				seen.eoc = in_ch.end_of_channel;
				due = predict_blend(seen);
				blends_due.insert(blends_due.size(), due);
			end
			if (cfg_we) begin
				case (acm_pkg::cfg_reg_t'(cfg_index))
					acm_pkg::REG_FADE_START: p_start = cfg_data & 24'hFFFFFF;
					acm_pkg::REG_FADE_END:   p_end = cfg_data & 24'hFFFFFF;
					acm_pkg::REG_COSINE:     p_cos = cfg_data[0];
					acm_pkg::REG_SKEW:       p_skew = cfg_data[15:0];
					default: ;
				endcase
			end
			if (out_ch.valid && out_ch.ready) begin
				got.sample = out_ch.blended_sample;
				got.last = out_ch.blend_last;
				if (blends_due.size() == 0) begin
					report_mismatch("output word with nothing expected");
				end else begin
					want = blends_due.pop_front();
					if (got.sample !== want.sample)
						report_mismatch($sformatf("blended_sample %h, expected %h",
							got.sample, want.sample));
					if (got.last !== want.last)
						report_mismatch($sformatf("blend_last %b, expected %b",
							got.last, want.last));
				end
			end
		end
	end

	// Driver: offer queued frames, hold each until taken, idle in bursts
	always @(negedge clk) begin
		static int in_gap = 0;
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.outgoing_sample <= '0;
			in_ch.incoming_sample <= '0;
			in_ch.end_of_channel <= 1'b0;
		end else begin
			if (in_fire) void'(frames_to_send.pop_front());
			if (in_ch.valid && !in_fire) begin
				// hold the offered word
			end else if (in_gap > 0) begin
				in_gap--;
				in_ch.valid <= 1'b0;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				in_gap = $urandom_range(0, 5);
				in_ch.valid <= 1'b0;
			end else if (frames_to_send.size() != 0) begin
				in_ch.outgoing_sample <= frames_to_send[0].a;
				in_ch.incoming_sample <= frames_to_send[0].b;
				in_ch.end_of_channel <= frames_to_send[0].eoc;
				in_ch.valid <= 1'b1;
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	// Receiver: long hold when requested, otherwise random stall bursts
	always @(negedge clk) begin
		static int out_gap = 0;
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else if (out_hold > 0) begin
			out_hold--;
			out_ch.ready <= 1'b0;
		end else if (out_gap > 0) begin
			out_gap--;
			out_ch.ready <= 1'b0;
		end else if (!quiet && $urandom_range(0, 7) == 0) begin
			out_gap = $urandom_range(0, 5);
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= 1'b1;
		end
	end

	task automatic write_reg(acm_pkg::cfg_reg_t idx, logic [acm_pkg::CFG_BITS-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic drain();
		wait (frames_to_send.size() == 0 && blends_due.size() == 0);
		repeat (20) @(posedge clk);
	endtask

	function automatic logic [23:0] rand_sample();
		case ($urandom_range(0, 5))
			0: return 24'h800000;
			1: return 24'h7FFFFF;
			2: return 24'h000000;
			3: return 24'($urandom_range(0, 255)) - 24'd128;
			default: return 24'($urandom);
		endcase
	endfunction

	function automatic logic [acm_pkg::CFG_BITS-1:0] rand_skew();
		case ($urandom_range(0, 7))
			0: return 24'd512;
			1: return 24'd32768;
			2: return 24'd4096;
			3: return 24'd0;
			4: return 24'h00FFFF;
			5: return 24'($urandom);
			default: return 24'($urandom_range(512, 32768));
		endcase
	endfunction

	// Stimulus
	initial begin
		int s, e;
		for (int k = 0; k <= TBL; k++) begin
			longint unsigned sv, sq;
			sv = sine_q30((64'd3373259426 * k) / (2 * TBL));
			if (sv > (64'd1 << 30)) sv = 64'd1 << 30;
			sq = (sv * sv) >> 36;
			sin2_rom[k] = (sq > ONE) ? ONE : sq;
		end
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: reset defaults, sample extremes around a one-frame cut
		queue_frame(24'h800000, 24'h7FFFFF, 1'b0);
		queue_frame(24'h7FFFFF, 24'h800000, 1'b0);
		queue_frame(24'h800000, 24'h7FFFFF, 1'b0);
		queue_frame(24'h000000, 24'hFFFFFF, 1'b1);
		drain();
		// Directed: short cosine ramp, then hard cut with end below start
		write_reg(acm_pkg::REG_FADE_START, 24'd2);
		write_reg(acm_pkg::REG_FADE_END, 24'd10);
		write_reg(acm_pkg::REG_SKEW, 24'd4096);
		for (int k = 0; k < 12; k++)
			queue_frame(24'h7FFFFF, 24'h800000, k == 11);
		drain();
		write_reg(acm_pkg::REG_FADE_START, 24'd3);
		write_reg(acm_pkg::REG_FADE_END, 24'd1);
		write_reg(acm_pkg::REG_COSINE, 24'd0);
		for (int k = 0; k < 6; k++)
			queue_frame(24'h123456, 24'h800000, k == 5);
		drain();

		// Random phases
		for (int ph = 0; ph < 40; ph++) begin
			quiet = (ph >= 36);
			case ($urandom_range(0, 9))
				0: begin s = 0; e = 0; end
				1: begin s = 24'hFFFFFF; e = 24'hFFFFFF; end
				2: begin s = $urandom_range(0, 10); e = 24'hFFFFFF; end
				3: begin s = $urandom_range(0, 20); e = $urandom_range(0, s); end
				default: begin s = $urandom_range(0, 15); e = s + $urandom_range(1, 30); end
			endcase
			write_reg(acm_pkg::REG_FADE_START, 24'(s));
			write_reg(acm_pkg::REG_FADE_END, 24'(e));
			write_reg(acm_pkg::REG_COSINE,
				{23'($urandom_range(0, 255)), 1'($urandom_range(0, 1))});
			write_reg(acm_pkg::REG_SKEW, rand_skew());
			if (ph == 5) out_hold = 300;
			for (int k = 0; k < 20; k++)
				queue_frame(rand_sample(), rand_sample(), $urandom_range(0, 24) == 0);
			drain();
		end

		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("audio_crossfade_contour_mixer_core test passed");
		else
			$display("audio_crossfade_contour_mixer_core test failed");
		$finish;
	end

	initial begin
		#30ms;
		$display("audio_crossfade_contour_mixer_core test failed");
		$finish;
	end
endmodule
